// ===== rtl/core/rfd_pkg.sv =====
// Shared types and constants for the response frame deframer.
// Holds the parse phase encoding, status codes and the result record.
// No dependencies.
package rfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 1'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hBD;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST  = 8'd32;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DISCARD  = 3'd4;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_SEQ     = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic                emit;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data_byte;
        logic [BYTE_W-1:0]   byte_index;
        logic [BYTE_W-1:0]   sequence_number;
        logic [BYTE_W-1:0]   frame_length;
    } result_t;

endpackage

// ===== rtl/core/rfd_parser.sv =====
// Frame parser: phase, sequence, length, payload count and running XOR.
// Produces at most one result per stepped byte, combinationally.
// Depends on rfd_pkg.
module rfd_parser
    import rfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] start_marker,
    input  logic [BYTE_W-1:0] max_payload,
    output result_t           res
);

    phase_t            phase_reg,   phase_next;
    logic [BYTE_W-1:0] seq_reg,     seq_next;
    logic [BYTE_W-1:0] len_reg,     len_next;
    logic [BYTE_W-1:0] count_reg,   count_next;
    logic [BYTE_W-1:0] xor_reg,     xor_next;
    logic [BYTE_W-1:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        res        = '0;
        res.data_byte = rx_byte;

        case (phase_reg)
            PH_SEQ:
            begin
                seq_next   = rx_byte;
                xor_next   = xor_reg ^ rx_byte;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                len_next   = rx_byte;
                xor_next   = xor_reg ^ rx_byte;
                count_next = '0;
                if (rx_byte > max_payload)
                begin
                    phase_next          = PH_HUNT;
                    res.emit            = 1'b1;
                    res.status          = ST_TOO_LONG;
                    res.sequence_number = seq_reg;
                    res.frame_length    = rx_byte;
                end
                else if (rx_byte == '0)
                    phase_next = PH_CHECK;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                xor_next   = xor_reg ^ rx_byte;
                count_next = count_inc;
                if (count_inc >= len_reg)
                    phase_next = PH_CHECK;
                res.emit            = 1'b1;
                res.status          = ST_PAYLOAD;
                res.byte_index      = count_reg;
                res.sequence_number = seq_reg;
                res.frame_length    = len_reg;
            end
            PH_CHECK:
            begin
                phase_next          = PH_HUNT;
                res.emit            = 1'b1;
                res.status          = (rx_byte == xor_reg) ? ST_OK : ST_BAD_CS;
                res.sequence_number = seq_reg;
                res.frame_length    = len_reg;
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (rx_byte == start_marker)
                begin
                    xor_next   = rx_byte;
                    phase_next = PH_SEQ;
                end
                else
                begin
                    res.emit   = 1'b1;
                    res.status = ST_DISCARD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            seq_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            xor_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

// ===== rtl/core/response_frame_deframer_top.sv =====
// Top level of the response frame deframer: input register, parser, result register.
// Holds the configuration registers. Depends on rfd_pkg and rfd_parser.
//
//   channel   signals                                   role
//   cfg       cfg_we, cfg_index, cfg_data               register write, no handshake
//   in        in_valid, in_ready, rx_byte               one received byte per transaction
//   out       out_valid, out_ready, status, data_byte,  zero or one result per byte
//             byte_index, sequence_number, frame_length
//
// A byte accepted goes into the input register, then through the parser into the
// result register. A new byte is taken every cycle while the output is not stalled.
// A stalled result holds the result register, which holds the input register; the
// input stays ready while the input register can advance. Reset clears the parse
// phase to hunting and restores start_marker 0xBD and max_payload 32.
module response_frame_deframer_top
    import rfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    // byte input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    // result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [BYTE_W-1:0]    data_byte,
    output logic [BYTE_W-1:0]    byte_index,
    output logic [BYTE_W-1:0]    sequence_number,
    output logic [BYTE_W-1:0]    frame_length
);

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] max_payload_reg;

    // input register stage
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register stage
    logic              out_vld_reg;
    result_t           res_reg;
    result_t           res_next;

    logic out_free;
    logic step;

    // result register can load when empty or being drained this cycle
    assign out_free = !out_vld_reg || out_ready;
    // a byte in the input register moves on whether or not it yields a result
    assign step     = in_vld_reg && out_free;
    assign in_ready = !in_vld_reg || step;

    // configuration writes; the user must write only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            max_payload_reg  <= MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_data;
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    rfd_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .start_marker (start_marker_reg),
        .max_payload  (max_payload_reg),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_free)
            out_vld_reg <= step && res_next.emit;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_next.emit)
            res_reg <= res_next;
    end

    assign out_valid       = out_vld_reg;
    assign status          = res_reg.status;
    assign data_byte       = res_reg.data_byte;
    assign byte_index      = res_reg.byte_index;
    assign sequence_number = res_reg.sequence_number;
    assign frame_length    = res_reg.frame_length;

endmodule
